[rtl/ccw_pkg.sv]
// Shared constants, command codes and the command record for the text console cell writer.
package ccw_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_COLS_DEF    = 80;
    localparam int MAX_ROWS_DEF    = 25;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Reset size of the visible window.
    localparam int DEF_VIS_COLS = 80;
    localparam int DEF_VIS_ROWS = 25;

    // Character and color constants.
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_BLANK     = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'h0F;

    // Input operation codes.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VIS_COLS = 2'd0;
    localparam logic [1:0] CFG_VIS_ROWS = 2'd1;
    localparam logic [1:0] CFG_COLOR    = 2'd2;

    // Command kinds decided by the front end.
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_CHAR      = 3'd0;
    localparam kind_t KIND_NEWLINE   = 3'd1;
    localparam kind_t KIND_BACKSPACE = 3'd2;
    localparam kind_t KIND_CLEAR     = 3'd3;
    localparam kind_t KIND_READ      = 3'd4;
    localparam kind_t KIND_READ_MISS = 3'd5;
    localparam kind_t KIND_NOP       = 3'd6;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } cmd_t;

endpackage

[rtl/text_console_cell_writer_core.sv]
// Top level of the text console cell writer: front end, command queue and back end.
// After a command leaves the queue: put, newline, backspace, out-of-range reads and unused ops
// answer from the output register, a read goes through the registered store read, and a clear
// sweeps every cell; a scroll copies the visible rows up one row and then blanks the last row.
// Throughput: one command at a time in the back end, one per cycle for the short ones while m_tready holds.
// Reset: synchronous, active low; s_tready then stays low while every cell of the store is blanked.
module text_console_cell_writer_core
    import ccw_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration writes: 0 visible_columns, 1 visible_rows, 2 text_color.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,

    // Input transactions.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code [7:0], read_row [12:8], read_col [19:13], zero
    input  logic [1:0]  s_tuser,   // op [1:0]

    // Result transactions.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // cell_value [15:0], cursor_row [20:16],
                                   // cursor_col [27:21], zero [31:28]
);

    // Commands classified by the front end wait here until the back end is free.
    cmd_t        push_cmd;
    cmd_t        head_cmd;
    logic        push;
    logic        pop;
    logic        queue_empty;
    logic        queue_full;
    logic        init_busy;
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;

    // The front end decodes the op and the control characters and checks read bounds,
    // so the back end only ever sees one of a handful of command kinds.
    ccw_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_op        (s_tuser),
        .s_char_code (s_tdata[7:0]),
        .s_read_row  (s_tdata[12:8]),
        .s_read_col  (s_tdata[19:13]),
        .queue_full  (queue_full),
        .init_busy   (init_busy),
        .push        (push),
        .cmd         (push_cmd)
    );

    // The queue lets the input side keep taking transactions during a long scroll or clear.
    ccw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // The back end owns the cell store and the cursor. It takes the next command only when
    // its output register is free or being emptied, so a result still waiting is never overwritten.
    ccw_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .head_cmd     (head_cmd),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .init_busy    (init_busy),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_cell_value (cell_value),
        .m_cursor_row (cursor_row),
        .m_cursor_col (cursor_col)
    );

    assign m_tdata = {4'd0, cursor_col, cursor_row, cell_value};

endmodule

[rtl/ccw_front.sv]
// Front end: accepts input transactions and classifies them into commands.
module ccw_front
    import ccw_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_char_code,
    input  logic [4:0] s_read_row,
    input  logic [6:0] s_read_col,
    input  logic       queue_full,
    input  logic       init_busy,
    output logic       push,
    output cmd_t       cmd
);

    logic read_in_store;

    assign s_tready      = !queue_full && !init_busy;
    assign push          = s_tvalid && s_tready;
    assign read_in_store = (32'(s_read_row) < MAX_ROWS) && (32'(s_read_col) < MAX_COLS);

    always_comb begin
        cmd.char_code = s_char_code;
        cmd.read_row  = s_read_row;
        cmd.read_col  = s_read_col;
        case (s_op)
            OP_PUT: begin
                if (s_char_code == CH_NEWLINE) begin
                    cmd.kind = KIND_NEWLINE;
                end else if (s_char_code == CH_BACKSPACE) begin
                    cmd.kind = KIND_BACKSPACE;
                end else begin
                    cmd.kind = KIND_CHAR;
                end
            end
            OP_CLEAR: cmd.kind = KIND_CLEAR;
            OP_READ:  cmd.kind = read_in_store ? KIND_READ : KIND_READ_MISS;
            default:  cmd.kind = KIND_NOP;
        endcase
    end

endmodule

[rtl/ccw_queue.sv]
// Small command queue between the front end and the back end.
module ccw_queue
    import ccw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign head_cmd = slots[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/ccw_back.sv]
// Back end: cell store, cursor, size registers and the command sequencer.
module ccw_back
    import ccw_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  cmd_t        head_cmd,
    input  logic        queue_empty,
    output logic        pop,
    output logic        init_busy,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_cell_value,
    output logic [4:0]  m_cursor_row,
    output logic [6:0]  m_cursor_col
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
    localparam logic [6:0] VC_RST = 7'((MAX_COLS < DEF_VIS_COLS) ? MAX_COLS : DEF_VIS_COLS);
    localparam logic [4:0] VR_RST = 5'((MAX_ROWS < DEF_VIS_ROWS) ? MAX_ROWS : DEF_VIS_ROWS);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_COPY  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_BLANK = 3'd6;

    logic [15:0]   mem [DEPTH];
    logic [15:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata;

    logic [2:0]    state_reg, state_next;
    logic [6:0]    vis_cols_reg, vis_cols_next;
    logic [4:0]    vis_rows_reg, vis_rows_next;
    logic [7:0]    color_reg, color_next;
    logic [4:0]    cur_row_reg, cur_row_next;
    logic [6:0]    cur_col_reg, cur_col_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [AW-1:0] base_reg, base_next;
    logic [4:0]    srow_reg, srow_next;
    logic [6:0]    scol_reg, scol_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          m_valid_reg, m_valid_next;
    logic [15:0]   m_cell_reg, m_cell_next;
    logic [4:0]    m_row_reg, m_row_next;
    logic [6:0]    m_col_reg, m_col_next;

    logic          out_free;
    logic [AW-1:0] cur_base;
    logic [4:0]    adv_row;
    logic [6:0]    adv_col;
    logic [6:0]    sat_cols;
    logic [4:0]    sat_rows;

    assign out_free  = !m_valid_reg || m_tready;
    assign pop       = (state_reg == ST_IDLE) && !queue_empty && out_free;
    assign init_busy = (state_reg == ST_INIT);
    assign cur_base  = AW'(32'(cur_row_reg) * MAX_COLS);

    assign m_tvalid     = m_valid_reg;
    assign m_cell_value = m_cell_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cursor_col = m_col_reg;

    // Saturate written sizes into the range the store can hold.
    always_comb begin
        if (cfg_wr_data[6:0] == 7'd0) begin
            sat_cols = 7'd1;
        end else if (32'(cfg_wr_data[6:0]) > MAX_COLS) begin
            sat_cols = 7'(MAX_COLS);
        end else begin
            sat_cols = cfg_wr_data[6:0];
        end
        if (cfg_wr_data[4:0] == 5'd0) begin
            sat_rows = 5'd1;
        end else if (32'(cfg_wr_data[4:0]) > MAX_ROWS) begin
            sat_rows = 5'(MAX_ROWS);
        end else begin
            sat_rows = cfg_wr_data[4:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        vis_cols_next  = vis_cols_reg;
        vis_rows_next  = vis_rows_reg;
        color_next     = color_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        sweep_next     = sweep_reg;
        base_next      = base_reg;
        srow_next      = srow_reg;
        scol_next      = scol_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_cell_next    = m_cell_reg;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = {color_reg, CH_BLANK};
        mem_raddr      = '0;
        adv_row        = cur_row_reg;
        adv_col        = cur_col_reg;

        case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = {RESET_COLOR, CH_BLANK};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_A) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (pop) begin
                    case (head_cmd.kind)
                        KIND_CHAR, KIND_NEWLINE: begin
                            if (head_cmd.kind == KIND_CHAR) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_base + AW'(cur_col_reg);
                                mem_wdata = {color_reg, head_cmd.char_code};
                            end
                            if (head_cmd.kind == KIND_NEWLINE ||
                                {1'b0, cur_col_reg} + 8'd1 >= {1'b0, vis_cols_reg}) begin
                                adv_col = 7'd0;
                                adv_row = cur_row_reg + 5'd1;
                            end else begin
                                adv_col = cur_col_reg + 7'd1;
                            end
                            cur_col_next = adv_col;
                            if (adv_row >= vis_rows_reg) begin
                                // Passing the last row starts a scroll.
                                cur_row_next = vis_rows_reg - 5'd1;
                                scol_next    = 7'd0;
                                pend_next    = 1'b0;
                                if (vis_rows_reg == 5'd1) begin
                                    base_next  = '0;
                                    state_next = ST_BLANK;
                                end else begin
                                    base_next  = COLS_A;
                                    srow_next  = 5'd1;
                                    state_next = ST_COPY;
                                end
                            end else begin
                                cur_row_next = adv_row;
                                m_valid_next = 1'b1;
                                m_cell_next  = 16'd0;
                                m_row_next   = adv_row;
                                m_col_next   = adv_col;
                            end
                        end
                        KIND_BACKSPACE: begin
                            adv_col = cur_col_reg;
                            if (cur_col_reg != 7'd0) begin
                                adv_col   = cur_col_reg - 7'd1;
                                mem_we    = 1'b1;
                                mem_waddr = cur_base + AW'(adv_col);
                            end
                            cur_col_next = adv_col;
                            m_valid_next = 1'b1;
                            m_cell_next  = 16'd0;
                            m_row_next   = cur_row_reg;
                            m_col_next   = adv_col;
                        end
                        KIND_CLEAR: begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        KIND_READ: begin
                            mem_raddr  = AW'(32'(head_cmd.read_row) * MAX_COLS
                                             + 32'(head_cmd.read_col));
                            state_next = ST_READ;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_cell_next  = 16'd0;
                            m_row_next   = cur_row_reg;
                            m_col_next   = cur_col_reg;
                        end
                    endcase
                end
            end

            ST_READ: begin
                m_valid_next = 1'b1;
                m_cell_next  = rd_data_reg;
                m_row_next   = cur_row_reg;
                m_col_next   = cur_col_reg;
                state_next   = ST_IDLE;
            end

            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_A) begin
                    cur_row_next = 5'd0;
                    cur_col_next = 7'd0;
                    m_valid_next = 1'b1;
                    m_cell_next  = 16'd0;
                    m_row_next   = 5'd0;
                    m_col_next   = 7'd0;
                    state_next   = ST_IDLE;
                end
            end

            ST_COPY: begin
                // Read a source cell while the previous one is written one row up.
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = rd_data_reg;
                end
                mem_raddr      = base_reg + AW'(scol_reg);
                pend_next      = 1'b1;
                pend_addr_next = base_reg - COLS_A + AW'(scol_reg);
                if (scol_reg == vis_cols_reg - 7'd1) begin
                    scol_next = 7'd0;
                    if (srow_reg == vis_rows_reg - 5'd1) begin
                        state_next = ST_DRAIN;
                    end else begin
                        srow_next = srow_reg + 5'd1;
                        base_next = base_reg + COLS_A;
                    end
                end else begin
                    scol_next = scol_reg + 7'd1;
                end
            end

            ST_DRAIN: begin
                mem_we     = 1'b1;
                mem_waddr  = pend_addr_reg;
                mem_wdata  = rd_data_reg;
                pend_next  = 1'b0;
                scol_next  = 7'd0;
                state_next = ST_BLANK;
            end

            ST_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + AW'(scol_reg);
                if (scol_reg == vis_cols_reg - 7'd1) begin
                    m_valid_next = 1'b1;
                    m_cell_next  = 16'd0;
                    m_row_next   = cur_row_reg;
                    m_col_next   = cur_col_reg;
                    state_next   = ST_IDLE;
                end else begin
                    scol_next = scol_reg + 7'd1;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The user makes size writes only while idle (not enforced); the cursor is pulled into the window.
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_VIS_COLS: begin
                    vis_cols_next = sat_cols;
                    if (cur_col_reg >= sat_cols) begin
                        cur_col_next = sat_cols - 7'd1;
                    end
                end
                CFG_VIS_ROWS: begin
                    vis_rows_next = sat_rows;
                    if (cur_row_reg >= sat_rows) begin
                        cur_row_next = sat_rows - 5'd1;
                    end
                end
                CFG_COLOR: begin
                    color_next = cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            vis_cols_reg <= VC_RST;
            vis_rows_reg <= VR_RST;
            color_reg    <= RESET_COLOR;
            cur_row_reg  <= 5'd0;
            cur_col_reg  <= 7'd0;
            sweep_reg    <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vis_cols_reg <= vis_cols_next;
            vis_rows_reg <= vis_rows_next;
            color_reg    <= color_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            sweep_reg    <= sweep_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg      <= base_next;
        srow_reg      <= srow_next;
        scol_reg      <= scol_next;
        pend_addr_reg <= pend_addr_next;
        m_cell_reg    <= m_cell_next;
        m_row_reg     <= m_row_next;
        m_col_reg     <= m_col_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule
